FILE: hdl/clip_text_pretokenizer_assert.svh
// Assertion macros used by the port checker.
// Each use expects clk and rst_n in scope.
`ifndef CLIP_TEXT_PRETOKENIZER_ASSERT_SVH
`define CLIP_TEXT_PRETOKENIZER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ctp_pkg.sv
package ctp_pkg;

    // Class of the run that the last emitted character belongs to
    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_LETTER = 2'd1,
        RUN_OTHER  = 2'd2,
        RUN_DIGIT  = 2'd3
    } ctp_run_t;

    // Number of held lookahead characters
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // Most results one character can produce
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        ctp_run_t   run_class;
        logic [1:0] pend_cnt;
        ctp_run_t   pend_run;
    } ctp_state_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        has_char;
        logic        word_start;
        logic        end_of_text;
    } ctp_result_t;

    // Results of one step, slot 0 first
    typedef struct packed {
        logic [1:0]                        count;
        ctp_result_t [MAX_RESULTS-1:0]     item;
    } ctp_push_t;

endpackage

FILE: hdl/ctp_if.sv
interface ctp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        text_end;

    modport source (output valid, output code_unit, output text_end, input ready);
    modport sink   (input valid, input code_unit, input text_end, output ready);
endinterface

interface ctp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_char;
    logic        has_char;
    logic        word_start;
    logic        end_of_text;

    modport source (output valid, output out_char, output has_char, output word_start,
                    output end_of_text, input ready);
    modport sink   (input valid, input out_char, input has_char, input word_start,
                    input end_of_text, output ready);
endinterface

FILE: hdl/ctp_step.sv
module ctp_step (
    input  logic [15:0]        code_unit,
    input  logic               text_end,
    input  ctp_pkg::ctp_state_t state,
    input  logic [15:0]        pend_char,
    output ctp_pkg::ctp_state_t state_next,
    output logic [15:0]        pend_char_next,
    output ctp_pkg::ctp_push_t  push
);
    import ctp_pkg::*;

    localparam logic [15:0] CHAR_APOS    = 16'h0027;
    localparam logic [15:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [15:0] CHAR_UPPER_Z = 16'h005A;
    localparam logic [15:0] CASE_OFFSET  = 16'd32;
    localparam logic [15:0] ASCII_TOP    = 16'h007F;
    localparam logic [15:0] CHAR_D       = 16'h0064;
    localparam logic [15:0] CHAR_E       = 16'h0065;
    localparam logic [15:0] CHAR_L       = 16'h006C;
    localparam logic [15:0] CHAR_M       = 16'h006D;
    localparam logic [15:0] CHAR_R       = 16'h0072;
    localparam logic [15:0] CHAR_S       = 16'h0073;
    localparam logic [15:0] CHAR_T       = 16'h0074;
    localparam logic [15:0] CHAR_V       = 16'h0076;

    function automatic logic is_space(input logic [15:0] c);
        return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        return c >= 16'h0030 && c <= 16'h0039;
    endfunction

    function automatic logic is_letter(input logic [15:0] c);
        return (c >= 16'h0061 && c <= 16'h007A) || (c > ASCII_TOP);
    endfunction

    logic [15:0]                   ch;
    logic                          is_stmd;
    logic                          is_rvl;
    logic                          hit;
    logic                          plain;
    logic [1:0]                    n;
    ctp_run_t                      rc;
    ctp_run_t                      prc;
    logic [1:0]                    pc;
    logic [15:0]                   sec;
    ctp_result_t [MAX_RESULTS-1:0] slot;

    assign ch = (code_unit >= CHAR_UPPER_A && code_unit <= CHAR_UPPER_Z)
              ? code_unit + CASE_OFFSET : code_unit;

    assign is_stmd = (ch == CHAR_S) || (ch == CHAR_T) || (ch == CHAR_M) || (ch == CHAR_D);
    assign is_rvl  = (ch == CHAR_R) || (ch == CHAR_V) || (ch == CHAR_L);
    assign hit     = ((pend_char == CHAR_R || pend_char == CHAR_V) && ch == CHAR_E)
                   || (pend_char == CHAR_L && ch == CHAR_L);

    always_comb
    begin
        rc    = state.run_class;
        pc    = state.pend_cnt;
        prc   = state.pend_run;
        sec   = pend_char;
        n     = 2'd0;
        plain = 1'b0;
        slot  = '0;

        case (state.pend_cnt)
            PEND_ONE:
            begin
                if (is_stmd)
                begin
                    slot[n] = '{CHAR_APOS, 1'b1, 1'b1, 1'b0};
                    n = n + 2'd1;
                    slot[n] = '{ch, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    rc = RUN_NONE;
                    pc = PEND_NONE;
                end
                else if (is_rvl)
                begin
                    sec = ch;
                    pc  = PEND_TWO;
                end
                else
                begin
                    // lone apostrophe falls back to a symbol
                    slot[n] = '{CHAR_APOS, 1'b1, prc != RUN_OTHER, 1'b0};
                    n = n + 2'd1;
                    rc    = RUN_OTHER;
                    pc    = PEND_NONE;
                    plain = 1'b1;
                end
            end
            PEND_TWO:
            begin
                pc = PEND_NONE;
                if (hit)
                begin
                    slot[n] = '{CHAR_APOS, 1'b1, 1'b1, 1'b0};
                    n = n + 2'd1;
                    slot[n] = '{pend_char, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    slot[n] = '{ch, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    rc = RUN_NONE;
                end
                else
                begin
                    slot[n] = '{CHAR_APOS, 1'b1, prc != RUN_OTHER, 1'b0};
                    n = n + 2'd1;
                    // held r/v/l follows a symbol, so it always opens a letter word
                    slot[n] = '{pend_char, 1'b1, 1'b1, 1'b0};
                    n = n + 2'd1;
                    rc    = RUN_LETTER;
                    plain = 1'b1;
                end
            end
            default:
            begin
                pc    = PEND_NONE;
                plain = 1'b1;
            end
        endcase

        if (plain)
        begin
            if (ch == CHAR_APOS)
            begin
                prc = rc;
                pc  = PEND_ONE;
            end
            else if (is_space(ch))
            begin
                rc = RUN_NONE;
            end
            else if (is_digit(ch))
            begin
                slot[n] = '{ch, 1'b1, 1'b1, 1'b0};
                n = n + 2'd1;
                rc = RUN_DIGIT;
            end
            else if (is_letter(ch))
            begin
                slot[n] = '{ch, 1'b1, rc != RUN_LETTER, 1'b0};
                n = n + 2'd1;
                rc = RUN_LETTER;
            end
            else
            begin
                slot[n] = '{ch, 1'b1, rc != RUN_OTHER, 1'b0};
                n = n + 2'd1;
                rc = RUN_OTHER;
            end
        end

        if (text_end)
        begin
            // flush held characters; a partial contraction never completes
            if (pc != PEND_NONE)
            begin
                slot[n] = '{CHAR_APOS, 1'b1, prc != RUN_OTHER, 1'b0};
                n = n + 2'd1;
                if (pc == PEND_TWO)
                begin
                    slot[n] = '{sec, 1'b1, 1'b1, 1'b0};
                    n = n + 2'd1;
                end
            end
            if (n == 2'd0)
            begin
                slot[0] = '{16'h0000, 1'b0, 1'b0, 1'b0};
                n = 2'd1;
            end
            slot[n - 2'd1].end_of_text = 1'b1;
            rc  = RUN_NONE;
            pc  = PEND_NONE;
            prc = RUN_NONE;
        end
    end

    assign state_next     = '{run_class: rc, pend_cnt: pc, pend_run: prc};
    assign pend_char_next = sec;
    assign push           = '{count: n, item: slot};

endmodule

FILE: hdl/ctp_result_queue.sv
module ctp_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  ctp_pkg::ctp_push_t push,
    output logic              room,
    ctp_out_if.source         word_out
);
    import ctp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctp_result_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [PTR_W-1:0]  offset [DEPTH];
    logic [1:0]        push_n;
    logic              pop;

    assign push_n = push_en ? push.count : 2'd0;
    assign pop    = word_out.valid && word_out.ready;
    // room for a full step's worth of results
    assign room   = count_reg <= CNT_W'(DEPTH - MAX_RESULTS);

    always_comb
    begin
        for (int e = 0; e < DEPTH; e++)
        begin
            offset[e] = PTR_W'(e) - wr_ptr_reg;
        end
    end

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < DEPTH; e++)
        begin
            if (push_en && (offset[e] < push.count))
            begin
                entry_reg[e] <= push.item[offset[e]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign word_out.valid       = count_reg != '0;
    assign word_out.out_char    = entry_reg[rd_ptr_reg].out_char;
    assign word_out.has_char    = entry_reg[rd_ptr_reg].has_char;
    assign word_out.word_start  = entry_reg[rd_ptr_reg].word_start;
    assign word_out.end_of_text = entry_reg[rd_ptr_reg].end_of_text;

endmodule

FILE: hdl/clip_text_pretokenizer.sv
// Word splitter for a CLIP-style tokenizer front end. Each request on text_in carries one
// 16-bit code unit; A-Z are lowercased and every kept character leaves on word_out with
// word_start set on the first character of each word. Whitespace separates words and is
// dropped, each digit is a word, letters (a-z and anything above 0x7F) form runs, other
// symbols form runs, and the contractions 's 't 're 've 'm 'll 'd are words of their own.
// An apostrophe, and an r/v/l after it, are held back until the next character decides;
// on text_end they are flushed and the last result carries end_of_text (a text that
// yields nothing gives one marker result with has_char low). State returns to reset
// after each text. Timing: a request is registered, then decoded combinationally into up
// to three results that go into a 4-entry result queue, from which word_out is driven.
// One request per cycle is taken while each yields at most one result and word_out is
// not stalled; a request with more results holds later ones back, since the output port
// carries a single result, which is what limits throughput. No clearing pass after reset.
module clip_text_pretokenizer (
    input  logic     clk,
    input  logic     rst_n,
    ctp_in_if.sink   text_in,
    ctp_out_if.source word_out
);
    import ctp_pkg::*;

    // input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [15:0] s1_code_reg;
    logic        s1_end_reg;

    // splitter state
    ctp_state_t  state_reg;
    ctp_state_t  state_next;
    logic [15:0] pend_char_reg;
    logic [15:0] pend_char_next;

    ctp_push_t   push;
    logic        room;
    logic        advance;
    logic        accept;

    // the registered request moves into the queue when all its results fit
    assign advance       = s1_valid_reg && room;
    assign text_in.ready = !s1_valid_reg || room;
    assign accept        = text_in.valid && text_in.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '{run_class: RUN_NONE, pend_cnt: PEND_NONE, pend_run: RUN_NONE};
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg <= text_in.code_unit;
            s1_end_reg  <= text_in.text_end;
        end
        if (advance)
        begin
            pend_char_reg <= pend_char_next;
        end
    end

    ctp_step u_step (
        .code_unit      (s1_code_reg),
        .text_end       (s1_end_reg),
        .state          (state_reg),
        .pend_char      (pend_char_reg),
        .state_next     (state_next),
        .pend_char_next (pend_char_next),
        .push           (push)
    );

    ctp_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_en  (advance),
        .push     (push),
        .room     (room),
        .word_out (word_out)
    );

endmodule

FILE: hdl/ctp_port_checker.sv
`include "clip_text_pretokenizer_assert.svh"

module ctp_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_char,
    input logic        has_char,
    input logic        word_start,
    input logic        end_of_text
);

    // high until the first result of the current text is taken
    logic text_fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_fresh_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            text_fresh_reg <= end_of_text;
        end
    end

    `CTP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({out_char, has_char, word_start, end_of_text}),
        "result changed while stalled")

    `CTP_ASSERT_NOW(a_marker_only, out_valid && !has_char,
        end_of_text && !word_start && out_char == 16'h0000,
        "empty result is not a clean end marker")

    `CTP_ASSERT_NOW(a_first_starts_word, out_valid && text_fresh_reg && has_char,
        word_start, "first character of a text does not start a word")

    `CTP_ASSERT_NOW(a_stall_has_cause, in_valid && !in_ready, out_valid,
        "input stalled with no result waiting")

endmodule

bind clip_text_pretokenizer ctp_port_checker u_ctp_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (text_in.valid),
    .in_ready    (text_in.ready),
    .out_valid   (word_out.valid),
    .out_ready   (word_out.ready),
    .out_char    (word_out.out_char),
    .has_char    (word_out.has_char),
    .word_start  (word_out.word_start),
    .end_of_text (word_out.end_of_text)
);

FILE: test/ctp_word_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts the word split of every accepted request and
// compares each accepted result against the oldest prediction.
module ctp_word_checker (
    input  logic clk,
    input  logic rst_n,
    ctp_in_if    text_in,
    ctp_out_if   word_out,
    output int   error_count,
    output int   results_due
);
    import ctp_pkg::*;

    localparam logic [15:0] APOSTROPHE  = 16'h0027;
    localparam logic [15:0] UPPER_A     = 16'h0041;
    localparam logic [15:0] UPPER_Z     = 16'h005A;
    localparam logic [15:0] LOWER_A     = 16'h0061;
    localparam logic [15:0] LOWER_Z     = 16'h007A;
    localparam logic [15:0] ASCII_TOP   = 16'h007F;
    localparam logic [15:0] CASE_OFFSET = 16'd32;
    localparam logic [15:0] DIGIT_ZERO  = 16'h0030;
    localparam logic [15:0] DIGIT_NINE  = 16'h0039;
    localparam logic [15:0] SPACE_CHAR  = 16'h0020;
    localparam logic [15:0] TAB_CHAR    = 16'h0009;
    localparam logic [15:0] CR_CHAR     = 16'h000D;
    localparam logic [15:0] CH_S        = 16'h0073;
    localparam logic [15:0] CH_T        = 16'h0074;
    localparam logic [15:0] CH_M        = 16'h006D;
    localparam logic [15:0] CH_D        = 16'h0064;
    localparam logic [15:0] CH_R        = 16'h0072;
    localparam logic [15:0] CH_V        = 16'h0076;
    localparam logic [15:0] CH_L        = 16'h006C;
    localparam logic [15:0] CH_E        = 16'h0065;

    ctp_run_t    run_cls;
    logic [1:0]  held_cnt;
    logic [15:0] held_second;
    ctp_run_t    held_run;
    ctp_result_t word_q[$];
    int          step_results;
    int          mismatches;

    function automatic bit is_space(input logic [15:0] c);
        return c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR);
    endfunction

    function automatic bit is_letter(input logic [15:0] c);
        return (c >= LOWER_A && c <= LOWER_Z) || c > ASCII_TOP;
    endfunction

    function automatic bit is_digit(input logic [15:0] c);
        return c >= DIGIT_ZERO && c <= DIGIT_NINE;
    endfunction

    task automatic clear_state();
        run_cls     = RUN_NONE;
        held_cnt    = PEND_NONE;
        held_second = '0;
        held_run    = RUN_NONE;
    endtask

    task automatic put_char(input logic [15:0] ch, input logic starts);
        ctp_result_t r;
        r.out_char    = ch;
        r.has_char    = 1'b1;
        r.word_start  = starts;
        r.end_of_text = 1'b0;
        word_q.push_back(r);
        step_results++;
    endtask

    // Character with nothing held back
    task automatic take_plain(input logic [15:0] c);
        if (c == APOSTROPHE)
        begin
            held_run = run_cls;
            held_cnt = PEND_ONE;
        end
        else if (is_space(c))
        begin
            run_cls = RUN_NONE;
        end
        else if (is_digit(c))
        begin
            put_char(c, 1'b1);
            run_cls = RUN_DIGIT;
        end
        else if (is_letter(c))
        begin
            put_char(c, run_cls != RUN_LETTER);
            run_cls = RUN_LETTER;
        end
        else
        begin
            put_char(c, run_cls != RUN_OTHER);
            run_cls = RUN_OTHER;
        end
    endtask

    // Held apostrophe turns out to be a plain symbol
    task automatic flush_apostrophe();
        put_char(APOSTROPHE, held_run != RUN_OTHER);
        run_cls = RUN_OTHER;
    endtask

    // Held r/v/l starts a letter word
    task automatic flush_second();
        put_char(held_second, run_cls != RUN_LETTER);
        run_cls = RUN_LETTER;
    endtask

    task automatic predict_step(input logic [15:0] unit, input logic last);
        logic [15:0] c;
        logic        hit;
        ctp_result_t tail;
        c = unit;
        if (c >= UPPER_A && c <= UPPER_Z)
            c = c + CASE_OFFSET;
        step_results = 0;
        case (held_cnt)
            PEND_ONE:
            begin
                if (c == CH_S || c == CH_T || c == CH_M || c == CH_D)
                begin
                    put_char(APOSTROPHE, 1'b1);
                    put_char(c, 1'b0);
                    run_cls  = RUN_NONE;
                    held_cnt = PEND_NONE;
                end
                else if (c == CH_R || c == CH_V || c == CH_L)
                begin
                    held_second = c;
                    held_cnt    = PEND_TWO;
                end
                else
                begin
                    held_cnt = PEND_NONE;
                    flush_apostrophe();
                    take_plain(c);
                end
            end
            PEND_TWO:
            begin
                hit = ((held_second == CH_R || held_second == CH_V) && c == CH_E) ||
                      (held_second == CH_L && c == CH_L);
                held_cnt = PEND_NONE;
                if (hit)
                begin
                    put_char(APOSTROPHE, 1'b1);
                    put_char(held_second, 1'b0);
                    put_char(c, 1'b0);
                    run_cls = RUN_NONE;
                end
                else
                begin
                    flush_apostrophe();
                    flush_second();
                    take_plain(c);
                end
            end
            default:
            begin
                held_cnt = PEND_NONE;
                take_plain(c);
            end
        endcase
        if (last)
        begin
            if (held_cnt != PEND_NONE)
            begin
                flush_apostrophe();
                if (held_cnt == PEND_TWO)
                    flush_second();
            end
            if (step_results == 0)
            begin
                tail = '0;
                word_q.push_back(tail);
            end
            tail = word_q.pop_back();
            tail.end_of_text = 1'b1;
            word_q.push_back(tail);
            clear_state();
        end
    endtask

    task automatic check_result();
        ctp_result_t seen;
        ctp_result_t want;
        seen.out_char    = word_out.out_char;
        seen.has_char    = word_out.has_char;
        seen.word_start  = word_out.word_start;
        seen.end_of_text = word_out.end_of_text;
        if (word_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result: expected none,", $time,
                     " got char=%h has=%b start=%b end=%b",
                     seen.out_char, seen.has_char, seen.word_start,
                     seen.end_of_text);
        end
        else
        begin
            want = word_q.pop_front();
            if (seen.out_char !== want.out_char || seen.has_char !== want.has_char ||
                seen.word_start !== want.word_start || seen.end_of_text !== want.end_of_text)
            begin
                mismatches++;
                $display("%0t: result mismatch:", $time,
                         " expected char=%h has=%b start=%b end=%b,",
                         want.out_char, want.has_char, want.word_start,
                         want.end_of_text,
                         " got char=%h has=%b start=%b end=%b",
                         seen.out_char, seen.has_char, seen.word_start,
                         seen.end_of_text);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            word_q.delete();
            mismatches = 0;
            error_count <= 0;
            results_due <= 0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
                predict_step(text_in.code_unit, text_in.text_end);
            if (word_out.valid && word_out.ready)
                check_result();
            error_count <= mismatches;
            results_due <= word_q.size();
        end
    end

endmodule

FILE: test/tb_clip_text_pretokenizer.sv
`timescale 1ns / 1ps

// Top of the word-splitter bench: clock, reset, request stimulus and output
// back-pressure. All prediction and comparison sits in ctp_word_checker.
module tb_clip_text_pretokenizer;

    import ctp_pkg::*;

    localparam int          CLK_HALF     = 4;       // 8 ns period
    localparam int          RESET_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int          UNITS_TOTAL  = 455;     // directed + ~430 random requests
    localparam int          CALM_FROM    = 385;     // no idling on either side past this
    localparam int          SETTLE       = 16;      // extra cycles after the last result
    localparam logic [15:0] APOSTROPHE   = 16'h0027;
    localparam logic [15:0] LOWER_A      = 16'h0061;
    localparam logic [15:0] LOWER_Z      = 16'h007A;
    localparam logic [15:0] CASE_OFFSET  = 16'd32;
    localparam logic [15:0] DIGIT_ZERO   = 16'h0030;
    localparam logic [15:0] SPACE_CHAR   = 16'h0020;
    localparam logic [15:0] TAB_CHAR     = 16'h0009;

    logic clk;
    logic rst_n;

    ctp_in_if  text_in_bus();
    ctp_out_if word_out_bus();

    int          error_count;
    int          results_due;
    int          units_sent;
    int          cycle_count;
    bit          calm_phase;
    logic [15:0] text_buf[$];

    clip_text_pretokenizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in_bus),
        .word_out (word_out_bus)
    );

    ctp_word_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_in     (text_in_bus),
        .word_out    (word_out_bus),
        .error_count (error_count),
        .results_due (results_due)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Watchdog: a hung handshake ends the run here
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output back-pressure: random stall bursts between ready stretches,
    // switched off once the run enters its calm tail.
    initial
    begin
        word_out_bus.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                word_out_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            word_out_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Randomly uppercases a-z; the block must fold it back
    function automatic logic [15:0] mixcase(input logic [15:0] c);
        if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 1) == 1)
            return c - CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [15:0] random_letter();
        return mixcase(LOWER_A + 16'($urandom_range(0, 25)));
    endfunction

    // Printable punctuation, control codes and DEL; never whitespace
    function automatic logic [15:0] random_symbol();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(16'h21, 16'h2F));
            1:       return 16'($urandom_range(16'h3A, 16'h40));
            2:       return 16'($urandom_range(16'h5B, 16'h60));
            3:       return 16'($urandom_range(16'h7B, 16'h7F));
            4:       return 16'($urandom_range(16'h00, 16'h08));
            default: return 16'($urandom_range(16'h0E, 16'h1F));
        endcase
    endfunction

    function automatic logic [15:0] random_space();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 5)
            return SPACE_CHAR;
        return TAB_CHAR + 16'(pick);
    endfunction

    task automatic queue_string(input string s, input bit mix);
        logic [15:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = {8'h00, s[i]};
            text_buf.push_back(mix ? mixcase(ch) : ch);
        end
    endtask

    // One request; an idle burst may come first. valid stays high across
    // back-to-back requests.
    task automatic send_unit(input logic [15:0] unit, input logic last);
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            text_in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        text_in_bus.valid     <= 1'b1;
        text_in_bus.code_unit <= unit;
        text_in_bus.text_end  <= last;
        @(posedge clk);
        while (!text_in_bus.ready) @(posedge clk);
    endtask

    // Sends the buffered text; its last unit carries text_end
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++) begin
            send_unit(text_buf[i], i == text_buf.size() - 1);
            units_sent++;
            if (units_sent >= CALM_FROM)
                calm_phase = 1'b1;
        end
        text_buf.delete();
    endtask

    // Mostly well-formed pieces (words, contractions) with random content;
    // broken contractions, lone apostrophes and raw 16-bit noise mixed in.
    // A text can stop right after a held ' or 'r/'v/'l.
    task automatic build_random_text();
        int target;
        target = $urandom_range(1, 14);
        while (text_buf.size() < target) begin
            case ($urandom_range(0, 11))
                0, 1:
                begin
                    text_buf.push_back(APOSTROPHE);
                    case ($urandom_range(0, 6))
                        0:       queue_string("s", 1'b1);
                        1:       queue_string("t", 1'b1);
                        2:       queue_string("m", 1'b1);
                        3:       queue_string("d", 1'b1);
                        4:       queue_string("re", 1'b1);
                        5:       queue_string("ve", 1'b1);
                        default: queue_string("ll", 1'b1);
                    endcase
                end
                2:
                begin
                    text_buf.push_back(APOSTROPHE);
                    case ($urandom_range(0, 2))
                        0:       queue_string("r", 1'b1);
                        1:       queue_string("v", 1'b1);
                        default: queue_string("l", 1'b1);
                    endcase
                    if ($urandom_range(0, 1) == 1)
                        text_buf.push_back(random_letter());
                end
                3, 4:
                    repeat ($urandom_range(1, 5)) text_buf.push_back(random_letter());
                5:
                    repeat ($urandom_range(1, 3)) text_buf.push_back(random_symbol());
                6:
                    repeat ($urandom_range(1, 3))
                        text_buf.push_back(DIGIT_ZERO + 16'($urandom_range(0, 9)));
                7, 8:
                    repeat ($urandom_range(1, 2)) text_buf.push_back(random_space());
                9:
                    text_buf.push_back(16'($urandom_range(16'h80, 16'hFFFF)));
                10:
                    text_buf.push_back(16'($urandom_range(0, 16'hFFFF)));
                default:
                    text_buf.push_back(APOSTROPHE);
            endcase
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        text_in_bus.valid     = 1'b0;
        text_in_bus.code_unit = '0;
        text_in_bus.text_end  = 1'b0;
        units_sent            = 0;
        calm_phase            = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes: 0x0000 and DEL are symbols, 0x0080 and 0xFFFF letters
        text_buf.push_back(16'h0000);
        text_buf.push_back(16'hFFFF);
        text_buf.push_back(16'h007F);
        text_buf.push_back(16'h0080);
        send_text();
        // Symbol run cut by 's, then 're, 'll, a digit word, and an apostrophe
        // after a digit that is no contraction
        queue_string("#'S'RE'lL9'x", 1'b0);
        send_text();
        // 'v broken by q, then 'r still held when the text ends
        queue_string("'vq 'r", 1'b0);
        send_text();
        // Whitespace only: just the end marker comes back
        queue_string(" ", 1'b0);
        send_text();
        // Lone held apostrophe flushed at the end
        queue_string("'", 1'b0);
        send_text();

        // Hold off until the block has drained everything so far
        text_in_bus.valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);

        while (units_sent < UNITS_TOTAL) begin
            build_random_text();
            send_text();
        end

        text_in_bus.valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
